FILE: hw/rtl/length_prefixed_frame_deframer_assert.svh
// Assertion macros used by the deframer core RTL.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define LPFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define LPFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/lpfd_pkg.sv
// Types and constants for the sync-word length-prefixed deframer.
`timescale 1ns / 1ps

package lpfd_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 16;
	localparam int CNT_W  = 32;

	// Register reset values
	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd148;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd195;
	localparam logic [LEN_W-1:0]  MAX_LENGTH_RST  = 16'd512;

	// Register indexes on the config port
	localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] CFG_MAX_LENGTH  = 2'd2;

	// Per-byte event code
	typedef enum logic [1:0] {
		EV_HEADER   = 2'd0,
		EV_PAYLOAD  = 2'd1,
		EV_SYNC_ERR = 2'd2,
		EV_LEN_ERR  = 2'd3
	} event_t;

	// Configuration registers as seen by the parser
	typedef struct packed {
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
		logic [LEN_W-1:0]  max_length;
	} cfg_t;

	// One result item
	typedef struct packed {
		event_t            ev;
		logic [BYTE_W-1:0] payload_byte;
		logic [LEN_W-1:0]  frame_length;
		logic              last_of_frame;
		logic [CNT_W-1:0]  sync_error_count;
		logic [CNT_W-1:0]  length_error_count;
	} res_t;

endpackage

FILE: hw/rtl/lpfd_core.sv
// Header parser, payload tracker and error counters of the deframer.
`timescale 1ns / 1ps
`include "length_prefixed_frame_deframer_assert.svh"

module lpfd_core
	import lpfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	input  cfg_t              cfg,
	output res_t              res
);

	typedef enum logic [4:0] {
		ST_HUNT1   = 5'b00001,
		ST_HUNT2   = 5'b00010,
		ST_LEN_HI  = 5'b00100,
		ST_LEN_LO  = 5'b01000,
		ST_PAYLOAD = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [BYTE_W-1:0] length_high_q, length_high_d;
	logic [LEN_W-1:0]  payload_length_q, payload_length_d;
	logic [LEN_W-1:0]  payload_index_q, payload_index_d;
	logic [CNT_W-1:0]  sync_errors_q, sync_errors_d;
	logic [CNT_W-1:0]  length_errors_q, length_errors_d;
	logic [LEN_W-1:0]  len_word;
	logic [LEN_W-1:0]  index_inc;

	assign len_word  = {length_high_q, rx_byte};
	assign index_inc = payload_index_q + LEN_W'(1);

	// Next state and result for the byte at hand
	always_comb begin
		state_d          = state_q;
		length_high_d    = length_high_q;
		payload_length_d = payload_length_q;
		payload_index_d  = payload_index_q;
		sync_errors_d    = sync_errors_q;
		length_errors_d  = length_errors_q;
		res.ev            = EV_HEADER;
		res.payload_byte  = '0;
		res.frame_length  = '0;
		res.last_of_frame = 1'b0;
		unique case (state_q)
			ST_HUNT1: begin
				if (rx_byte == cfg.sync_first) begin
					state_d = ST_HUNT2;
				end else begin
					sync_errors_d = sync_errors_q + CNT_W'(1);
					res.ev        = EV_SYNC_ERR;
				end
			end
			ST_HUNT2: begin
				// a mismatching byte is dropped, not retried as a first sync byte
				if (rx_byte == cfg.sync_second) begin
					state_d = ST_LEN_HI;
				end else begin
					sync_errors_d = sync_errors_q + CNT_W'(1);
					res.ev        = EV_SYNC_ERR;
					state_d       = ST_HUNT1;
				end
			end
			ST_LEN_HI: begin
				length_high_d = rx_byte;
				state_d       = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				payload_index_d = '0;
				if (len_word == '0 || len_word > cfg.max_length) begin
					length_errors_d  = length_errors_q + CNT_W'(1);
					res.ev           = EV_LEN_ERR;
					payload_length_d = '0;
					state_d          = ST_HUNT1;
				end else begin
					payload_length_d = len_word;
					state_d          = ST_PAYLOAD;
				end
			end
			ST_PAYLOAD: begin
				res.ev           = EV_PAYLOAD;
				res.payload_byte = rx_byte;
				res.frame_length = payload_length_q;
				payload_index_d  = index_inc;
				if (index_inc >= payload_length_q) begin
					res.last_of_frame = 1'b1;
					payload_index_d   = '0;
					payload_length_d  = '0;
					state_d           = ST_HUNT1;
				end
			end
			default: begin
				state_d = ST_HUNT1;
			end
		endcase
		res.sync_error_count   = sync_errors_d;
		res.length_error_count = length_errors_d;
	end

	// State registers, updated once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_HUNT1;
			length_high_q    <= '0;
			payload_length_q <= '0;
			payload_index_q  <= '0;
			sync_errors_q    <= '0;
			length_errors_q  <= '0;
		end else if (step) begin
			state_q          <= state_d;
			length_high_q    <= length_high_d;
			payload_length_q <= payload_length_d;
			payload_index_q  <= payload_index_d;
			sync_errors_q    <= sync_errors_d;
			length_errors_q  <= length_errors_d;
		end
	end

	`LPFD_ASSERT_NOW(a_index_below_length, state_q == ST_PAYLOAD, payload_index_q < payload_length_q, "payload index reached frame length")
	`LPFD_ASSERT_NEXT(a_last_back_to_hunt, step && res.last_of_frame, state_q == ST_HUNT1 && payload_index_q == '0, "no return to hunt after last byte")
	`LPFD_ASSERT_NEXT(a_sync_err_count, step && res.ev == EV_SYNC_ERR, sync_errors_q == $past(sync_errors_q) + CNT_W'(1) && length_errors_q == $past(length_errors_q), "sync error not counted once")
	`LPFD_ASSERT_NEXT(a_len_err_count, step && res.ev == EV_LEN_ERR, length_errors_q == $past(length_errors_q) + CNT_W'(1) && sync_errors_q == $past(sync_errors_q), "length error not counted once")

endmodule

FILE: hw/rtl/length_prefixed_frame_deframer.sv
// Top level of the sync-word length-prefixed deframer.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+----------------------------
//  rx      | rx_byte                                  | rx_valid / rx_stall
//  res     | event_res payload_byte frame_length      | res_valid / res_stall
//          | last_of_frame sync_error_count           |
//          | length_error_count                       |
//  cfg     | cfg_index cfg_data                       | cfg_valid / cfg_ready (always 1)
//
// One byte per cycle sustained while res_stall is low; path: input register, result register.
// Each byte passes one compare-and-count step between the two registers.
// Reset clears the parser state, counters and valid flags; registers return to defaults.
// A held result stalls a filled input register, which raises rx_stall in the same cycle.
`timescale 1ns / 1ps

module length_prefixed_frame_deframer
	import lpfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [1:0]        event_res,
	output logic [BYTE_W-1:0] payload_byte,
	output logic [LEN_W-1:0]  frame_length,
	output logic              last_of_frame,
	output logic [CNT_W-1:0]  sync_error_count,
	output logic [CNT_W-1:0]  length_error_count,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [LEN_W-1:0]  cfg_data
);

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	res_t              res_s2;
	res_t              res_next;
	logic              advance;

	// Configuration registers; an unknown index is ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= SYNC_FIRST_RST;
			cfg_q.sync_second <= SYNC_SECOND_RST;
			cfg_q.max_length  <= MAX_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_SYNC_FIRST) begin
				cfg_q.sync_first <= cfg_data[BYTE_W-1:0];
			end
			if (cfg_index == CFG_SYNC_SECOND) begin
				cfg_q.sync_second <= cfg_data[BYTE_W-1:0];
			end
			if (cfg_index == CFG_MAX_LENGTH) begin
				cfg_q.max_length <= cfg_data;
			end
		end
	end

	// Byte moves to the result register when that register is free or drained
	assign advance  = valid_s1 && (!valid_s2 || !res_stall);
	assign rx_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	lpfd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign res_valid          = valid_s2;
	assign event_res          = res_s2.ev;
	assign payload_byte       = res_s2.payload_byte;
	assign frame_length       = res_s2.frame_length;
	assign last_of_frame      = res_s2.last_of_frame;
	assign sync_error_count   = res_s2.sync_error_count;
	assign length_error_count = res_s2.length_error_count;

endmodule
